// ===== hw/rtl/bts_pkg.sv =====
package bts_pkg;

  // Task set size and field widths
  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = 3;
  localparam int MASK_W    = 8;
  localparam int CNT_W     = 8;

  // Bits of the ready mask that belong to real tasks
  localparam logic [MASK_W-1:0] TASK_MASK =
    MASK_W'((9'd1 << NUM_TASKS) - 9'd1);

  // Request opcodes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELAY  = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // Outcome of the priority pick
  typedef struct packed {
    logic              idle;
    logic [TASK_W-1:0] task_sel;
  } pick_t;

endpackage

// ===== hw/rtl/bts_pick.sv =====
module bts_pick (
  input  logic [bts_pkg::MASK_W-1:0] ready,
  output bts_pkg::pick_t             pick
);
  import bts_pkg::*;

  // Select the lowest-numbered ready task, flag idle when none is ready
  always_comb begin
    pick.idle     = 1'b1;
    pick.task_sel = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (ready[i]) begin
        pick.idle     = 1'b0;
        pick.task_sel = TASK_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/bitmap_task_scheduler.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_op, in_task_id, in_delay_ticks
// out_      output     out_valid/out_stall out_running_task, out_none_ready, out_ready_mask
//
// One request per cycle sustained while out_stall is low; results are registered.
// The scheduler state updates as a request moves from the input register into the result register.
// Synchronous active-low reset clears the ready mask, all wait counters and the running task.
// A stalled result holds while the input register still takes one more request.
module bitmap_task_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [2:0] in_task_id,
  input  logic [7:0] in_delay_ticks,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_running_task,
  output logic       out_none_ready,
  output logic [7:0] out_ready_mask
);
  import bts_pkg::*;

  // Input register
  logic              in_full_r, in_full_nxt;
  logic [1:0]        op_r;
  logic [TASK_W-1:0] id_r;
  logic [CNT_W-1:0]  ticks_r;

  // Scheduler state
  logic [MASK_W-1:0] ready_r, ready_nxt;
  logic [CNT_W-1:0]  ctr_r   [NUM_TASKS];
  logic [CNT_W-1:0]  ctr_nxt [NUM_TASKS];
  logic [TASK_W-1:0] cur_r, cur_nxt;
  logic              idle_r, idle_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0] out_task_r;
  logic              out_idle_r;
  logic [MASK_W-1:0] out_mask_r;

  logic  accept;
  logic  advance;
  pick_t pick;

  // Handshake: move the held request whenever the result slot is empty or its result is not stalled
  assign advance       = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall      = in_full_r && !advance;
  assign accept        = in_valid && !in_stall;
  assign in_full_nxt   = accept || (in_full_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // Update ready mask and wait counters for the held request
  always_comb begin
    ready_nxt = ready_r;
    ctr_nxt   = ctr_r;
    case (op_r)
      OP_CREATE: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (id_r == TASK_W'(i)) begin
            ready_nxt[i] = 1'b1;
            ctr_nxt[i]   = '0;
          end
        end
      end
      OP_DELAY: begin
        if (!idle_r) begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (cur_r == TASK_W'(i)) begin
              ready_nxt[i] = 1'b0;
              ctr_nxt[i]   = ticks_r;
            end
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (ctr_r[i] != '0) begin
            ctr_nxt[i] = ctr_r[i] - CNT_W'(1);
            if (ctr_r[i] == CNT_W'(1)) begin
              ready_nxt[i] = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  bts_pick u_pick (
    .ready (ready_nxt),
    .pick  (pick)
  );

  // Reschedule after a delay from a running task or after a tick
  always_comb begin
    cur_nxt  = cur_r;
    idle_nxt = idle_r;
    case (op_r)
      OP_DELAY: begin
        if (!idle_r) begin
          cur_nxt  = pick.task_sel;
          idle_nxt = pick.idle;
        end
      end
      OP_TICK: begin
        cur_nxt  = pick.task_sel;
        idle_nxt = pick.idle;
      end
      default: begin
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ready_r     <= '0;
      cur_r       <= '0;
      idle_r      <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        ctr_r[i] <= '0;
      end
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        ready_r <= ready_nxt;
        ctr_r   <= ctr_nxt;
        cur_r   <= cur_nxt;
        idle_r  <= idle_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      id_r    <= in_task_id;
      ticks_r <= in_delay_ticks;
    end
    if (advance) begin
      out_task_r <= cur_nxt;
      out_idle_r <= idle_nxt;
      out_mask_r <= ready_nxt & TASK_MASK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = out_task_r;
  assign out_none_ready   = out_idle_r;
  assign out_ready_mask   = out_mask_r;

endmodule

// ===== hw/rtl/bts_checker.sv =====
module bts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_running_task,
  input logic       out_none_ready,
  input logic [7:0] out_ready_mask
);

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An idle result reports task zero
  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_ready |-> out_running_task == 3'd0)
    else $error("idle result with nonzero running task");

  // A free result slot never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result slot empty");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_task)
      && $stable(out_none_ready) && $stable(out_ready_mask))
    else $error("stalled result changed");

endmodule

bind bitmap_task_scheduler bts_checker u_bts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_running_task (out_running_task),
  .out_none_ready   (out_none_ready),
  .out_ready_mask   (out_ready_mask)
);
